### design/wsdf_pkg.sv
// Shared codes and types for the WebSocket frame deframer.
// Used by the parser, the top level and the port checker; depends on nothing.
package wsdf_pkg;

    localparam int unsigned MAX_W = 17;
    localparam logic [MAX_W-1:0] MAX_PAYLOAD_RESET = 17'(64 * 1024);

    localparam logic [1:0] EV_DATA     = 2'd0;
    localparam logic [1:0] EV_EMPTY    = 2'd1;
    localparam logic [1:0] EV_CLOSE    = 2'd2;
    localparam logic [1:0] EV_OVERSIZE = 2'd3;

    localparam logic [3:0] OPC_CLOSE = 4'h8;
    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    typedef struct packed {
        logic       valid;
        logic [1:0] ev;
        logic [7:0] data;
        logic [3:0] opcode;
        logic       last;
    } t_result;

endpackage

### design/wsdf_parser.sv
// Frame header parser and payload unmasker for the WebSocket frame deframer.
// Holds the parse state; yields at most one result word per advanced byte. Uses wsdf_pkg.
module wsdf_parser (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_adv,
    input  logic [7:0]                  i_byte,
    input  logic [wsdf_pkg::MAX_W-1:0]  i_max_payload,
    output wsdf_pkg::t_result           o_res
);

    typedef enum logic [2:0] {
        PH_HDR0,
        PH_HDR1,
        PH_EXT,
        PH_KEY,
        PH_DATA,
        PH_HALT
    } t_phase;

    t_phase                      r_phase, n_phase;
    logic [3:0]                  r_opcode, n_opcode;
    logic                        r_masked, n_masked;
    logic [2:0]                  r_btg, n_btg;
    logic [wsdf_pkg::MAX_W-1:0]  r_len, n_len;
    logic                        r_ovf, n_ovf;
    logic [31:0]                 r_key, n_key;
    logic [1:0]                  r_idx, n_idx;

    logic                        len_done;
    logic                        hdr_done;
    logic [wsdf_pkg::MAX_W-1:0]  cand_len;
    logic                        cand_ovf;
    logic [7:0]                  kb;
    logic                        lst;

    always_comb begin
        n_phase  = r_phase;
        n_opcode = r_opcode;
        n_masked = r_masked;
        n_btg    = r_btg;
        n_len    = r_len;
        n_ovf    = r_ovf;
        n_key    = r_key;
        n_idx    = r_idx;
        len_done = 1'b0;
        hdr_done = 1'b0;
        cand_len = r_len;
        cand_ovf = r_ovf;
        kb       = 8'd0;
        lst      = 1'b0;
        o_res    = '{valid: 1'b0, ev: wsdf_pkg::EV_DATA, data: 8'd0,
                     opcode: r_opcode, last: 1'b1};

        unique case (r_phase)
            PH_HDR0: begin
                n_opcode = i_byte[3:0];
                n_phase  = PH_HDR1;
            end
            PH_HDR1: begin
                n_masked = i_byte[7];
                n_key    = 32'd0;
                n_len    = '0;
                n_ovf    = 1'b0;
                if (i_byte[6:0] == wsdf_pkg::LEN_EXT16) begin
                    n_phase = PH_EXT;
                    n_btg   = 3'd1;
                end else if (i_byte[6:0] == wsdf_pkg::LEN_EXT64) begin
                    n_phase = PH_EXT;
                    n_btg   = 3'd7;
                end else begin
                    cand_len = wsdf_pkg::MAX_W'(i_byte[6:0]);
                    cand_ovf = 1'b0;
                    len_done = 1'b1;
                end
            end
            PH_EXT: begin
                cand_len = {r_len[wsdf_pkg::MAX_W-9:0], i_byte};
                cand_ovf = r_ovf | (|r_len[wsdf_pkg::MAX_W-1:wsdf_pkg::MAX_W-8]);
                n_len    = cand_len;
                n_ovf    = cand_ovf;
                if (r_btg == 3'd0) begin
                    len_done = 1'b1;
                end else begin
                    n_btg = r_btg - 3'd1;
                end
            end
            PH_KEY: begin
                n_key = {r_key[23:0], i_byte};
                if (r_btg == 3'd0) begin
                    hdr_done = 1'b1;
                end else begin
                    n_btg = r_btg - 3'd1;
                end
            end
            PH_DATA: begin
                unique case (r_idx)
                    2'd0: kb = r_key[31:24];
                    2'd1: kb = r_key[23:16];
                    2'd2: kb = r_key[15:8];
                    2'd3: kb = r_key[7:0];
                endcase
                n_idx = r_idx + 2'd1;
                n_len = r_len - wsdf_pkg::MAX_W'(1);
                lst   = (r_len == wsdf_pkg::MAX_W'(1));
                if (r_opcode == wsdf_pkg::OPC_CLOSE) begin
                    if (lst) begin
                        n_phase = PH_HALT;
                        o_res.valid = 1'b1;
                        o_res.ev    = wsdf_pkg::EV_CLOSE;
                    end
                end else begin
                    if (lst) begin
                        n_phase = PH_HDR0;
                    end
                    o_res.valid = 1'b1;
                    o_res.ev    = wsdf_pkg::EV_DATA;
                    o_res.data  = i_byte ^ kb;
                    o_res.last  = lst;
                end
            end
            default: begin
                n_phase = PH_HALT;
            end
        endcase

        if (len_done) begin
            n_len = cand_len;
            n_ovf = cand_ovf;
            if (cand_ovf || (cand_len > i_max_payload)) begin
                n_phase     = PH_HALT;
                o_res.valid = 1'b1;
                o_res.ev    = wsdf_pkg::EV_OVERSIZE;
            end else if (n_masked) begin
                n_phase = PH_KEY;
                n_btg   = 3'd3;
            end else begin
                hdr_done = 1'b1;
            end
        end

        if (hdr_done) begin
            n_idx = 2'd0;
            if (n_len == '0) begin
                o_res.valid = 1'b1;
                if (r_opcode == wsdf_pkg::OPC_CLOSE) begin
                    n_phase  = PH_HALT;
                    o_res.ev = wsdf_pkg::EV_CLOSE;
                end else begin
                    n_phase  = PH_HDR0;
                    o_res.ev = wsdf_pkg::EV_EMPTY;
                end
            end else begin
                n_phase = PH_DATA;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HDR0;
            r_opcode <= 4'd0;
            r_masked <= 1'b0;
            r_btg    <= 3'd0;
            r_len    <= '0;
            r_ovf    <= 1'b0;
            r_key    <= 32'd0;
            r_idx    <= 2'd0;
        end else if (i_adv) begin
            r_phase  <= n_phase;
            r_opcode <= n_opcode;
            r_masked <= n_masked;
            r_btg    <= n_btg;
            r_len    <= n_len;
            r_ovf    <= n_ovf;
            r_key    <= n_key;
            r_idx    <= n_idx;
        end
    end

endmodule

### design/websocket_frame_deframer.sv
// WebSocket frame deframer, receive side.
// Byte input channel and result output channel, both valid/stall, with a
// one-register configuration port for the payload length limit.
// A byte accepted on the input is held in an input register; the parser
// consumes it from there when the output register is empty or being taken,
// and its result word, if any, is loaded into the output register.
// Throughput is one byte per cycle while the receiver does not stall, set by
// the single parser pass between the input register and the output register.
// Header bytes produce no data word; non-close payload bytes give one word each;
// an empty frame, a close frame end or an oversize length gives one event word.
// After a close or an oversize event the block drops every further byte.
// Synchronous reset returns the parser to the first header byte, empties
// both registers and sets max_payload to 65536.
// When the receiver stalls, the output word holds and the input register
// fills; the input then stalls until the output word is taken.
// Depends on wsdf_pkg and wsdf_parser.
module websocket_frame_deframer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [wsdf_pkg::MAX_W-1:0]  i_cfg_wdata,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [7:0]                  i_byte_in,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [1:0]                  o_event_res,
    output logic [7:0]                  o_data_out,
    output logic [3:0]                  o_frame_opcode,
    output logic                        o_last
);

    logic [wsdf_pkg::MAX_W-1:0] r_max_payload;
    logic                       r_in_valid;
    logic [7:0]                 r_in_byte;
    wsdf_pkg::t_result          r_out;
    wsdf_pkg::t_result          res;
    logic                       adv;

    assign adv        = r_in_valid && (!r_out.valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !adv;

    wsdf_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_adv         (adv),
        .i_byte        (r_in_byte),
        .i_max_payload (r_max_payload),
        .o_res         (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_payload <= wsdf_pkg::MAX_PAYLOAD_RESET;
            r_in_valid    <= 1'b0;
            r_in_byte     <= 8'd0;
            r_out         <= '0;
        end else begin
            if (i_cfg_we) begin
                r_max_payload <= i_cfg_wdata;
            end
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (!o_in_stall && i_in_valid) begin
                r_in_byte <= i_byte_in;
            end
            if (adv) begin
                r_out <= res;
            end else if (!i_out_stall) begin
                r_out.valid <= 1'b0;
            end
        end
    end

    assign o_out_valid    = r_out.valid;
    assign o_event_res    = r_out.ev;
    assign o_data_out     = r_out.data;
    assign o_frame_opcode = r_out.opcode;
    assign o_last         = r_out.last;

endmodule

### design/wsdf_checker.sv
// Port-level checker for the WebSocket frame deframer, bound to the top level.
// Sees only the top-level ports; uses wsdf_pkg event codes.
module wsdf_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       o_in_stall,
    input  logic       o_out_valid,
    input  logic       i_out_stall,
    input  logic [1:0] o_event_res,
    input  logic [7:0] o_data_out,
    input  logic       o_last
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output word dropped while stalled");

    a_event_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_event_res != wsdf_pkg::EV_DATA) |-> (o_data_out == 8'd0) && o_last)
        else $error("event word with data or without last");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a stalled output word");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("output not empty after reset");

endmodule

bind websocket_frame_deframer wsdf_checker u_wsdf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_event_res (o_event_res),
    .o_data_out  (o_data_out),
    .o_last      (o_last)
);

### tb/sv/websocket_frame_deframer_tb.sv
// Testbench for websocket_frame_deframer: drives framed byte streams through
// the valid/stall input, predicts every result word and checks it in order.
// Depends on wsdf_pkg and the deframer RTL.
`timescale 1ns / 1ps

module websocket_frame_deframer_tb;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned RANDOM_BYTES = 300;
    localparam logic [wsdf_pkg::MAX_W-1:0] LIMIT_TOP = '1;

    typedef enum logic [2:0] {
        PH_HDR0, PH_HDR1, PH_EXT, PH_KEY, PH_DATA, PH_HALT
    } t_phase;

    typedef enum int {LEN_SHORT, LEN_16, LEN_64} t_len_form;

    typedef enum int {END_OVERSIZE, END_CLOSE_EMPTY, END_CLOSE_DATA} t_end_kind;

    typedef struct packed {
        logic [1:0] ev;
        logic [7:0] data;
        logic [3:0] opcode;
        logic       last;
    } t_word;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_cfg_we = 1'b0;
    logic [wsdf_pkg::MAX_W-1:0] i_cfg_wdata = '0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_stall;
    logic [7:0]                 i_byte_in = '0;
    logic                       o_out_valid;
    logic                       i_out_stall = 1'b0;
    logic [1:0]                 o_event_res;
    logic [7:0]                 o_data_out;
    logic [3:0]                 o_frame_opcode;
    logic                       o_last;

    websocket_frame_deframer uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_byte_in      (i_byte_in),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_event_res    (o_event_res),
        .o_data_out     (o_data_out),
        .o_frame_opcode (o_frame_opcode),
        .o_last         (o_last)
    );

    always #4 i_clk = ~i_clk;

    // parser state mirror
    t_phase                     ph = PH_HDR0;
    logic [3:0]                 cur_opc = '0;
    logic                       masked = 1'b0;
    logic [2:0]                 hdr_left = '0;
    logic [63:0]                remaining = '0;
    logic [31:0]                key = '0;
    logic [1:0]                 key_idx = '0;
    logic [wsdf_pkg::MAX_W-1:0] limit = wsdf_pkg::MAX_PAYLOAD_RESET;

    t_word            expected_words[$];
    t_word            got_word;
    t_word            want_word;
    int unsigned      errors = 0;
    int unsigned      words_checked = 0;
    int unsigned      bytes_sent = 0;
    int unsigned      frames_sent = 0;
    int unsigned      cycles = 0;
    bit               quiet = 1'b0;
    t_end_kind        end_kind;

    function automatic void push_word(input logic [1:0] ev, input logic [7:0] data,
                                      input logic last);
        t_word w;
        w.ev = ev;
        w.data = data;
        w.opcode = cur_opc;
        w.last = last;
        expected_words.insert(expected_words.size(), w);
    endfunction

    function automatic void header_complete();
        key_idx = '0;
        if (remaining == 0) begin
            if (cur_opc == wsdf_pkg::OPC_CLOSE) begin
                ph = PH_HALT;
                push_word(wsdf_pkg::EV_CLOSE, 8'h00, 1'b1);
            end else begin
                ph = PH_HDR0;
                push_word(wsdf_pkg::EV_EMPTY, 8'h00, 1'b1);
            end
        end else begin
            ph = PH_DATA;
        end
    endfunction

    function automatic void length_known();
        if (remaining > 64'(limit)) begin
            ph = PH_HALT;
            push_word(wsdf_pkg::EV_OVERSIZE, 8'h00, 1'b1);
        end else if (masked) begin
            ph = PH_KEY;
            hdr_left = 3'd3;
        end else begin
            header_complete();
        end
    endfunction

    function automatic void deframe_byte(input logic [7:0] b);
        logic [7:0] kb;
        case (ph)
            PH_HDR0: begin
                cur_opc = b[3:0];
                ph = PH_HDR1;
            end
            PH_HDR1: begin
                masked = b[7];
                key = '0;
                remaining = '0;
                if (b[6:0] == wsdf_pkg::LEN_EXT16) begin
                    ph = PH_EXT;
                    hdr_left = 3'd1;
                end else if (b[6:0] == wsdf_pkg::LEN_EXT64) begin
                    ph = PH_EXT;
                    hdr_left = 3'd7;
                end else begin
                    remaining = 64'(b[6:0]);
                    length_known();
                end
            end
            PH_EXT: begin
                remaining = {remaining[55:0], b};
                if (hdr_left == 0) length_known();
                else hdr_left = hdr_left - 3'd1;
            end
            PH_KEY: begin
                key = {key[23:0], b};
                if (hdr_left == 0) header_complete();
                else hdr_left = hdr_left - 3'd1;
            end
            PH_DATA: begin
                kb = 8'(key >> (24 - 8 * int'(key_idx)));
                key_idx = key_idx + 2'd1;
                remaining = remaining - 64'd1;
                if (cur_opc == wsdf_pkg::OPC_CLOSE) begin
                    if (remaining == 0) begin
                        ph = PH_HALT;
                        push_word(wsdf_pkg::EV_CLOSE, 8'h00, 1'b1);
                    end
                end else begin
                    if (remaining == 0) ph = PH_HDR0;
                    push_word(wsdf_pkg::EV_DATA, b ^ kb, remaining == 0);
                end
            end
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input int want, input int got);
        $display("mismatch %s: expected %0d got %0d at cycle %0d", what, want, got, cycles);
        errors++;
    endtask

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("simulation failed");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_out_stall <= !quiet && ($urandom_range(99) < 12);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got_word = '{o_event_res, o_data_out, o_frame_opcode, o_last};
            if (expected_words.size() == 0) begin
                report_mismatch("unexpected word", -1, int'(got_word));
            end else begin
                want_word = expected_words.pop_front();
                words_checked++;
                if (got_word.ev != want_word.ev)
                    report_mismatch("event_res", int'(want_word.ev), int'(got_word.ev));
                if (got_word.data != want_word.data)
                    report_mismatch("data_out", int'(want_word.data), int'(got_word.data));
                if (got_word.opcode != want_word.opcode)
                    report_mismatch("frame_opcode", int'(want_word.opcode),
                                    int'(got_word.opcode));
                if (got_word.last != want_word.last)
                    report_mismatch("last", int'(want_word.last), int'(got_word.last));
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while (!quiet && $urandom_range(99) < 12) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_byte_in = b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        deframe_byte(b);
        bytes_sent++;
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    task automatic send_frame(input logic [3:0] opc, input logic mk, input t_len_form form,
                              input logic [63:0] len);
        logic [31:0]     k;
        longint unsigned n;
        k = mk ? $urandom : 32'd0;
        send_byte({4'($urandom), opc});
        case (form)
            LEN_SHORT: send_byte({mk, len[6:0]});
            LEN_16: begin
                send_byte({mk, wsdf_pkg::LEN_EXT16});
                send_byte(len[15:8]);
                send_byte(len[7:0]);
            end
            default: begin
                send_byte({mk, wsdf_pkg::LEN_EXT64});
                for (int i = 7; i >= 0; i--) send_byte(len[8*i +: 8]);
            end
        endcase
        if (mk && len <= 64'(limit))
            for (int i = 3; i >= 0; i--) send_byte(k[8*i +: 8]);
        if (len <= 64'(limit))
            for (n = 0; n < len; n++) send_byte(8'($urandom));
        frames_sent++;
    endtask

    task automatic wait_idle();
        while (expected_words.size() != 0) @(negedge i_clk);
        repeat (6) @(negedge i_clk);
    endtask

    task automatic write_limit(input logic [wsdf_pkg::MAX_W-1:0] v);
        wait_idle();
        i_cfg_we = 1'b1;
        i_cfg_wdata = v;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        limit = v;
    endtask

    function automatic logic [3:0] random_opcode();
        logic [3:0] o;
        o = 4'($urandom_range(14));
        return (o >= wsdf_pkg::OPC_CLOSE) ? o + 4'd1 : o;
    endfunction

    task automatic random_frame();
        int        r;
        int        lim;
        t_len_form form;
        int        len;
        lim = int'(limit);
        r = $urandom_range(99);
        if (r < 70) begin
            form = LEN_SHORT;
            len = $urandom_range(lim < 16 ? lim : 16, 0);
        end else if (r < 85) begin
            form = LEN_16;
            len = $urandom_range(lim < 300 ? lim : 300, 0);
        end else if (r < 95) begin
            form = LEN_64;
            len = $urandom_range(lim < 40 ? lim : 40, 0);
        end else begin
            form = LEN_SHORT;
            len = $urandom_range(lim < 125 ? lim : 125, lim < 100 ? lim : 100);
        end
        send_frame(random_opcode(), 1'($urandom), form, 64'(len));
    endtask

    task automatic test_basic_frames();
        send_frame(4'h1, 1'b0, LEN_SHORT, 64'd0);
        send_frame(4'h9, 1'b1, LEN_SHORT, 64'd0);
        send_frame(4'h2, 1'b0, LEN_SHORT, 64'd1);
        send_frame(4'hA, 1'b1, LEN_SHORT, 64'd4);
        send_frame(4'hF, 1'b1, LEN_16, 64'd6);
        send_frame(4'h0, 1'b0, LEN_64, 64'd2);
        send_frame(4'h3, 1'b1, LEN_16, 64'd0);
        send_frame(4'h7, 1'b0, LEN_64, 64'd0);
        send_frame(4'hB, 1'b0, LEN_SHORT, 64'd125);
        send_frame(4'h4, 1'b1, LEN_16, 64'd126);
    endtask

    task automatic test_zero_limit();
        write_limit('0);
        send_frame(4'h1, 1'b0, LEN_SHORT, 64'd0);
        send_frame(4'hC, 1'b1, LEN_SHORT, 64'd0);
        send_frame(4'h5, 1'b0, LEN_16, 64'd0);
        send_frame(4'hE, 1'b1, LEN_64, 64'd0);
    endtask

    task automatic test_limit_boundary();
        logic [wsdf_pkg::MAX_W-1:0] lim;
        lim = wsdf_pkg::MAX_W'($urandom_range(40, 1));
        write_limit(lim);
        send_frame(random_opcode(), 1'b1, LEN_SHORT, 64'(lim));
        send_frame(random_opcode(), 1'b0, LEN_16, 64'(lim));
        send_frame(random_opcode(), 1'b1, LEN_64, 64'(lim) - 64'd1);
        send_frame(random_opcode(), 1'b0, LEN_SHORT, 64'd0);
    endtask

    task automatic run_random(input int unsigned count, input int unsigned calm);
        int unsigned start;
        start = bytes_sent;
        while (bytes_sent - start < count) begin
            quiet = (bytes_sent - start) < calm;
            random_frame();
        end
        quiet = 1'b0;
    endtask

    task automatic test_random_traffic();
        write_limit(LIMIT_TOP);
        run_random(RANDOM_BYTES / 3, 150);
        write_limit(wsdf_pkg::MAX_W'($urandom_range(600, 50)));
        run_random(RANDOM_BYTES / 3, 0);
        write_limit(wsdf_pkg::MAX_PAYLOAD_RESET);
        run_random(RANDOM_BYTES / 3, 0);
    endtask

    task automatic test_halt();
        logic [63:0] len;
        end_kind = t_end_kind'($urandom_range(2));
        case (end_kind)
            END_OVERSIZE: begin
                len = 64'(limit) + 64'd1;
                if ($urandom_range(1)) len = len + ({$urandom, $urandom} >> 1);
                send_frame(random_opcode(), 1'($urandom), LEN_64, len);
            end
            END_CLOSE_EMPTY: send_frame(wsdf_pkg::OPC_CLOSE, 1'($urandom), LEN_SHORT, 64'd0);
            default: send_frame(wsdf_pkg::OPC_CLOSE, 1'b1, LEN_SHORT,
                                64'($urandom_range(10, 1)));
        endcase
        repeat (8) send_byte(8'($urandom));
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_basic_frames();
        test_zero_limit();
        test_limit_boundary();
        test_random_traffic();
        test_halt();
        wait_idle();
        repeat (10) @(negedge i_clk);
        if (expected_words.size() != 0)
            report_mismatch("words never delivered", 0, expected_words.size());
        $display("%0d frames, %0d bytes sent, %0d words checked, %0d mismatches",
                 frames_sent, bytes_sent, words_checked, errors);
        $display("ended on %s, limits zero, small, 0x%0h and reset value",
                 end_kind.name(), LIMIT_TOP);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
